// ===== rtl/tcw_pkg.sv =====
package tcw_pkg;

  localparam int FUNC_W = 2;
  localparam int BYTE_W = 8;
  localparam int IDX_W  = 11;
  localparam int CELL_W = 16;

  localparam logic [FUNC_W-1:0] FN_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FN_READ  = 2'd2;

  localparam logic [CELL_W-1:0] CHAR_ATTR  = 16'h0F00;
  localparam logic [CELL_W-1:0] GREEN_FILL = 16'hAA00;
  localparam logic [BYTE_W-1:0] NEWLINE    = 8'd10;
  localparam logic [BYTE_W-1:0] GREEN_SEL  = 8'd1;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] data_byte;
    logic [IDX_W-1:0]  read_index;
  } in_t;

  typedef struct packed {
    logic [CELL_W-1:0] read_cell;
    logic [IDX_W-1:0]  cursor_index;
    logic              scrolled;
  } out_t;

endpackage

// ===== rtl/tcw_ram.sv =====
module tcw_ram #(
  parameter int DEPTH  = 2000,
  parameter int ADDR_W = 11,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/tcw_ctrl.sv =====
module tcw_ctrl #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  parameter int ADDR_W  = 11
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  tcw_pkg::in_t               in_item,
  output logic                       busy,
  output logic                       done,
  output tcw_pkg::out_t              res,
  output logic                       ram_we,
  output logic [ADDR_W-1:0]          ram_waddr,
  output logic [tcw_pkg::CELL_W-1:0] ram_wdata,
  output logic                       ram_re,
  output logic [ADDR_W-1:0]          ram_raddr,
  input  logic [tcw_pkg::CELL_W-1:0] ram_rdata
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int CW    = $clog2(CELLS + 1);
  localparam int COLW  = $clog2(COLUMNS);

  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] LAST_DST  = ADDR_W'(CELLS - COLUMNS - 1);
  localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);
  localparam logic [CW-1:0]     PAST_END  = CW'(CELLS);
  localparam logic [CW-1:0]     LAST_ROW  = CW'(CELLS - COLUMNS);
  localparam logic [CW-1:0]     COLS_CW   = CW'(COLUMNS);
  localparam logic [COLW-1:0]   LAST_COL  = COLW'(COLUMNS - 1);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_FILL   = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_SCROLL = 3'd4;
  localparam logic [2:0] S_DRAIN  = 3'd5;
  localparam logic [2:0] S_ZERO   = 3'd6;
  localparam logic [2:0] S_FINISH = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [ADDR_W-1:0] wa_r, wa_nxt;
  logic              pend_r, pend_nxt;
  logic [CW-1:0]     cursor_r, cursor_nxt;
  logic [COLW-1:0]   col_r, col_nxt;
  logic [BYTE_W-1:0] data_r, data_nxt;
  logic [CELL_W-1:0] fill_r, fill_nxt;

  logic [BYTE_W-1:0] ch;
  logic              is_nl;
  logic [CW-1:0]     put_cursor;
  logic [COLW-1:0]   put_col;
  logic              do_put;

  assign ch    = (state_r == S_IDLE) ? in_item.data_byte : data_r;
  assign is_nl = (ch == NEWLINE);
  // newline: back to column zero, then one row down
  assign put_cursor = is_nl ? (cursor_r - CW'(col_r) + COLS_CW) : (cursor_r + 1'b1);
  assign put_col    = (is_nl || col_r == LAST_COL) ? '0 : (col_r + 1'b1);

  always_comb begin
    state_nxt  = state_r;
    addr_nxt   = addr_r;
    wa_nxt     = wa_r;
    pend_nxt   = pend_r;
    cursor_nxt = cursor_r;
    col_nxt    = col_r;
    data_nxt   = data_r;
    fill_nxt   = fill_r;
    ram_we     = 1'b0;
    ram_waddr  = addr_r;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = addr_r + ROW_STEP;
    done       = 1'b0;
    do_put     = 1'b0;
    res        = '0;

    unique case (state_r) inside
      S_INIT, S_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = (state_r == S_FILL) ? fill_r : '0;
        addr_nxt  = addr_r + 1'b1;
        if (addr_r == LAST_CELL) begin
          state_nxt = S_IDLE;
          if (state_r == S_FILL) begin
            done       = 1'b1;
            cursor_nxt = '0;
            col_nxt    = '0;
          end
        end
      end
      S_IDLE: begin
        if (start) begin
          case (in_item.func)
            FN_PUT: begin
              if (cursor_r == PAST_END) begin
                data_nxt   = in_item.data_byte;
                cursor_nxt = LAST_ROW;
                col_nxt    = '0;
                addr_nxt   = '0;
                pend_nxt   = 1'b0;
                state_nxt  = S_SCROLL;
              end else begin
                do_put = 1'b1;
                done   = 1'b1;
              end
            end
            FN_CLEAR: begin
              fill_nxt  = (in_item.data_byte == GREEN_SEL) ? GREEN_FILL : '0;
              addr_nxt  = '0;
              state_nxt = S_FILL;
            end
            FN_READ: begin
              if (32'(in_item.read_index) < CELLS) begin
                ram_re    = 1'b1;
                ram_raddr = ADDR_W'(in_item.read_index);
                state_nxt = S_READ;
              end else begin
                done = 1'b1;
              end
            end
            default: done = 1'b1;
          endcase
        end
      end
      S_READ: begin
        done          = 1'b1;
        res.read_cell = ram_rdata;
        state_nxt     = S_IDLE;
      end
      S_SCROLL: begin
        // read one row ahead, write back the word fetched last cycle
        ram_re    = 1'b1;
        ram_we    = pend_r;
        ram_waddr = wa_r;
        ram_wdata = ram_rdata;
        wa_nxt    = addr_r;
        pend_nxt  = 1'b1;
        addr_nxt  = addr_r + 1'b1;
        if (addr_r == LAST_DST) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        ram_we    = 1'b1;
        ram_waddr = wa_r;
        ram_wdata = ram_rdata;
        state_nxt = S_ZERO;
      end
      S_ZERO: begin
        ram_we   = 1'b1;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == LAST_CELL) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        do_put       = 1'b1;
        done         = 1'b1;
        res.scrolled = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    if (do_put) begin
      if (!is_nl) begin
        ram_we    = 1'b1;
        ram_waddr = cursor_r[ADDR_W-1:0];
        ram_wdata = CHAR_ATTR | {{(CELL_W-BYTE_W){1'b0}}, ch};
      end
      cursor_nxt = put_cursor;
      col_nxt    = put_col;
    end

    res.cursor_index = IDX_W'(cursor_nxt);
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_INIT;
      addr_r   <= '0;
      pend_r   <= 1'b0;
      cursor_r <= '0;
      col_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      addr_r   <= addr_nxt;
      pend_r   <= pend_nxt;
      cursor_r <= cursor_nxt;
      col_r    <= col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wa_r   <= wa_nxt;
    data_r <= data_nxt;
    fill_r <= fill_nxt;
  end

`ifndef ASSERT_OFF
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= PAST_END)
    else $error("cursor beyond past-end position");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= LAST_COL)
    else $error("column tracker out of range");

  a_put_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    do_put |-> cursor_r != PAST_END)
    else $error("character put while cursor past end");

  a_scroll_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH) |=> (cursor_r == LAST_ROW + COLS_CW || cursor_r == LAST_ROW + 1'b1))
    else $error("cursor after scroll not on last row");

  a_no_result_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INIT) |-> !done)
    else $error("result during clearing pass");
`endif

endmodule

// ===== rtl/text_console_writer_unit.sv =====
// Channel   Ports                            Transfer
// input     start, busy, in_item             start && !busy at clk edge
// result    out_valid, out_item              one-cycle strobe, always taken
//
// Put of a character or newline: busy stays low, result in the next cycle.
// Read: busy while an in-range cell is fetched. Clear: writes every cell, one cell per cycle.
// Put at the past-end position scrolls the screen up a row, zeroes the last
// row and then puts, bounded by the single write port of the screen memory.
// After reset a clearing pass zeroes every cell of the screen; busy
// stays high until it ends. Results are never held off by the receiver.
module text_console_writer_unit #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  tcw_pkg::in_t  in_item,
  output logic          busy,
  output logic          out_valid,
  output tcw_pkg::out_t out_item
);
  import tcw_pkg::*;

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);

  logic              done;
  out_t              res;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  logic out_valid_r;
  out_t out_item_r;

  tcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .ADDR_W  (ADDR_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .done      (done),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  tcw_ram #(
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W),
    .DATA_W (CELL_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import tcw_pkg::*;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int PHASE_ITEMS = 333;
  // every item could be a full-screen scroll or clear; several times that
  localparam int LIMIT = 12_000_000;

  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

  class console_scoreboard;
    logic [CELL_W-1:0] screen [CELLS];
    int unsigned cursor;
    out_t due_results [$];
    int mismatches;

    function new();
      foreach (screen[i]) screen[i] = '0;
      cursor = 0;
      mismatches = 0;
    endfunction

    // Advance the console state by one accepted item and queue its result.
    function void note_item(in_t it);
      out_t want;
      want = '0;
      case (it.func)
        FN_PUT: begin
          if (cursor >= CELLS) begin
            for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
            for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = '0;
            cursor = CELLS - COLUMNS;
            want.scrolled = 1'b1;
          end
          if (it.data_byte == NEWLINE) begin
            cursor = (cursor / COLUMNS + 1) * COLUMNS;
          end else begin
            screen[cursor] = CHAR_ATTR | it.data_byte;
            cursor++;
          end
        end
        FN_CLEAR: begin
          foreach (screen[i]) screen[i] = (it.data_byte == GREEN_SEL) ? GREEN_FILL : '0;
          cursor = 0;
        end
        FN_READ: begin
          if (it.read_index < CELLS) want.read_cell = screen[it.read_index];
        end
        default: ;
      endcase
      want.cursor_index = cursor[IDX_W-1:0];
      due_results.push_back(want);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("[%0t] %s: got %0h, expected %0h", $time, what, got, want);
      mismatches++;
    endtask

    task check_result(out_t got);
      out_t want;
      if (due_results.size() == 0) begin
        report("result with nothing pending", 32'(got), 32'd0);
        return;
      end
      want = due_results.pop_front();
      if (got.read_cell !== want.read_cell)
        report("read_cell", 32'(got.read_cell), 32'(want.read_cell));
      if (got.cursor_index !== want.cursor_index)
        report("cursor_index", 32'(got.cursor_index), 32'(want.cursor_index));
      if (got.scrolled !== want.scrolled)
        report("scrolled", 32'(got.scrolled), 32'(want.scrolled));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  in_t  in_item = '0;
  logic busy;
  logic out_valid;
  out_t out_item;

  int cycles = 0;
  int sender_idle_pct [4] = '{0, 47, 0, 11};
  console_scoreboard sb = new();

  always #2 clk = ~clk;

  text_console_writer_unit #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .in_item(in_item),
    .busy(busy),
    .out_valid(out_valid),
    .out_item(out_item)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else if (rst_n && out_valid === 1'b1) begin
      sb.check_result(out_item);
    end
  end

  function automatic in_t item_of(logic [FUNC_W-1:0] f, logic [BYTE_W-1:0] b,
                                  logic [IDX_W-1:0] idx);
    in_t it;
    it.func = f;
    it.data_byte = b;
    it.read_index = idx;
    return it;
  endfunction

  // Mostly text with line breaks; reads often look at the last written cell.
  function automatic in_t random_item();
    int unsigned pick;
    in_t it;
    pick = $urandom_range(99);
    it.func = FN_PUT;
    it.data_byte = BYTE_W'($urandom_range(255));
    it.read_index = IDX_W'($urandom_range(2047));
    if (pick >= 73 && pick < 81) begin
      it.data_byte = NEWLINE;
    end else if (pick >= 81 && pick < 97) begin
      it.func = FN_READ;
      if (pick < 89 && sb.cursor > 0) it.read_index = IDX_W'(sb.cursor - 1);
    end else if (pick == 97) begin
      it.func = FN_CLEAR;
      if ($urandom_range(1) == 1) it.data_byte = GREEN_SEL;
    end else if (pick > 97) begin
      it.func = FN_UNUSED;
    end
    return it;
  endfunction

  // Called at a clock edge; returns at the edge that takes the item.
  task automatic send_item(input in_t it);
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sb.note_item(it);
  endtask

  task automatic idle_gap(input int pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.due_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(item_of(FN_READ, 8'h00, 11'd0));
    send_item(item_of(FN_PUT, 8'h00, 11'd0));
    send_item(item_of(FN_PUT, 8'hFF, 11'h7FF));
    send_item(item_of(FN_READ, 8'hFF, 11'd1));
    send_item(item_of(FN_READ, 8'h00, 11'(CELLS - 1)));
    send_item(item_of(FN_READ, 8'h00, 11'(CELLS)));
    send_item(item_of(FN_READ, 8'h00, 11'h7FF));
    send_item(item_of(FN_UNUSED, 8'hFF, 11'h7FF));
    send_item(item_of(FN_CLEAR, GREEN_SEL, 11'd0));
    send_item(item_of(FN_READ, 8'h00, 11'(CELLS - 1)));
    send_item(item_of(FN_CLEAR, 8'h81, 11'd0));
    send_item(item_of(FN_PUT, 8'h41, 11'd0));
    // walk down to the bottom; the last newline lands past the end
    repeat (ROWS) send_item(item_of(FN_PUT, NEWLINE, 11'd0));
    send_item(item_of(FN_PUT, NEWLINE, 11'd0));
    send_item(item_of(FN_PUT, 8'h5A, 11'd0));
    send_item(item_of(FN_READ, 8'h00, 11'(CELLS - COLUMNS)));
    drain();

    for (int p = 0; p < 4; p++) begin
      repeat (PHASE_ITEMS) begin
        idle_gap(sender_idle_pct[p]);
        send_item(random_item());
      end
      drain();
    end

    repeat (CELLS + 8) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/tcw_ctrl.sv
rtl/text_console_writer_unit.sv
test/tb.sv
